@@ rtl/lfd_pkg.sv @@
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared constants, status codes and types for the LED frame deframer.
// ----------------------------------------------------------------------------
package lfd_pkg;

    // Frame geometry.
    localparam int LED_COUNT   = 15;
    localparam int MAX_RESULTS = 15;
    localparam int STORE_SIZE  = 3 * LED_COUNT;
    localparam int STORE_AW    = $clog2(STORE_SIZE + 1);
    localparam int LED_LIMIT   = (LED_COUNT < MAX_RESULTS) ? LED_COUNT : MAX_RESULTS;

    // Marker bytes of the frame.
    localparam logic [7:0] HEAD1_BYTE = 8'h2E;
    localparam logic [7:0] HEAD2_BYTE = 8'h13;
    localparam logic [7:0] FOOT1_BYTE = 8'hF2;
    localparam logic [7:0] FOOT2_BYTE = 8'h13;

    // Result status codes.
    localparam logic [2:0] ST_LED_WRITE = 3'd0;
    localparam logic [2:0] ST_FRAME_OK  = 3'd1;
    localparam logic [2:0] ST_BAD_HEAD1 = 3'd2;
    localparam logic [2:0] ST_BAD_HEAD2 = 3'd3;
    localparam logic [2:0] ST_PARITY    = 3'd4;
    localparam logic [2:0] ST_BAD_FOOT1 = 3'd5;
    localparam logic [2:0] ST_BAD_FOOT2 = 3'd6;

    // Write request into the color store.
    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

endpackage

@@ rtl/lfd_store.sv @@
// ----------------------------------------------------------------------------
// lfd_store
// Color byte store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfd_store (
    input  logic                        aclk,
    input  lfd_pkg::store_wr_t          wr,
    input  logic [lfd_pkg::STORE_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);

    logic [7:0] mem [lfd_pkg::STORE_SIZE];
    logic [7:0] rd_data_reg;

    // Write port, used while payload bytes arrive.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Read port with registered data; addresses past the end read nothing new.
    always_ff @(posedge aclk) begin
        if (rd_addr < lfd_pkg::STORE_AW'(lfd_pkg::STORE_SIZE)) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/led_frame_deframer_top.sv @@
// ----------------------------------------------------------------------------
// led_frame_deframer_top
// Parses serial bytes into LED frames and emits one color write per LED.
// ----------------------------------------------------------------------------
// Header, length, payload and footer bytes are each taken on a handshake, as
// is a byte that gives an error status. After a good second footer byte the
// block reads the stored colors back through the single read port of the
// color store, one byte per cycle while no output transfer is waiting: each
// LED write takes a prime step and a step each for red, green and blue, then
// waits for the output transfer, and the input stays stalled until the last
// LED write is transferred. A frame with no complete triplet gives one
// status-only result instead.
module led_frame_deframer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [3:0] m_led_index,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic       m_last
);

    localparam int AW = lfd_pkg::STORE_AW;
    localparam logic [3:0] LED_MAX = 4'(lfd_pkg::LED_LIMIT);

    // Sequencer codes.
    localparam logic [2:0] PH_HEAD1   = 3'd0;
    localparam logic [2:0] PH_HEAD2   = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;
    localparam logic [2:0] PH_FOOT1   = 3'd5;
    localparam logic [2:0] PH_FOOT2   = 3'd6;
    localparam logic [2:0] PH_READ    = 3'd7;

    // Readout step codes.
    localparam logic [1:0] RD_PRIME = 2'd0;
    localparam logic [1:0] RD_RED   = 2'd1;
    localparam logic [1:0] RD_GREEN = 2'd2;
    localparam logic [1:0] RD_BLUE  = 2'd3;

    logic [2:0]    phase_reg,  phase_next;
    logic [7:0]    len_reg,    len_next;
    logic [7:0]    cnt_reg,    cnt_next;
    logic          parity_reg, parity_next;
    logic [1:0]    tpos_reg,   tpos_next;
    logic [3:0]    trip_reg,   trip_next;
    logic [3:0]    idx_reg,    idx_next;
    logic [1:0]    sub_reg,    sub_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [7:0]    red_reg,    red_next;
    logic [7:0]    green_reg,  green_next;

    logic          m_valid_reg,  m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [3:0]    m_index_reg,  m_index_next;
    logic [7:0]    m_red_reg,    m_red_next;
    logic [7:0]    m_green_reg,  m_green_next;
    logic [7:0]    m_blue_reg,   m_blue_next;
    logic          m_last_reg,   m_last_next;

    lfd_pkg::store_wr_t store_wr;
    logic [7:0]         rd_data;
    logic               s_fire;
    logic               byte_par;
    logic [7:0]         cnt_inc;

    lfd_store u_store (
        .aclk    (aclk),
        .wr      (store_wr),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    // Input is taken only while parsing and when the output register is free.
    assign s_ready  = (phase_reg != PH_READ) && (!m_valid_reg || m_ready);
    assign s_fire   = s_valid && s_ready;
    assign byte_par = ^s_rx_byte;
    assign cnt_inc  = cnt_reg + 8'd1;

    // Frame parser and readout sequencer.
    always_comb begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        parity_next   = parity_reg;
        tpos_next     = tpos_reg;
        trip_next     = trip_reg;
        idx_next      = idx_reg;
        sub_next      = sub_reg;
        rd_addr_next  = rd_addr_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_index_next  = m_index_reg;
        m_red_next    = m_red_reg;
        m_green_next  = m_green_reg;
        m_blue_next   = m_blue_reg;
        m_last_next   = m_last_reg;
        store_wr.en   = 1'b0;
        store_wr.addr = cnt_reg[AW-1:0];
        store_wr.data = s_rx_byte;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (phase_reg)
            PH_HEAD1: begin
                if (s_fire) begin
                    if (s_rx_byte != lfd_pkg::HEAD1_BYTE) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_BAD_HEAD1;
                    end else begin
                        parity_next = byte_par;
                        phase_next  = PH_HEAD2;
                    end
                end
            end
            PH_HEAD2: begin
                if (s_fire) begin
                    if (s_rx_byte != lfd_pkg::HEAD2_BYTE) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_BAD_HEAD2;
                        phase_next    = PH_HEAD1;
                    end else begin
                        parity_next = parity_reg ^ byte_par;
                        phase_next  = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                if (s_fire) begin
                    len_next    = s_rx_byte;
                    cnt_next    = 8'd0;
                    tpos_next   = 2'd0;
                    trip_next   = 4'd0;
                    parity_next = parity_reg ^ byte_par;
                    phase_next  = (s_rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (s_fire) begin
                    // Keep the byte if it fits and count complete triplets.
                    store_wr.en = (cnt_reg < 8'(lfd_pkg::STORE_SIZE));
                    cnt_next    = cnt_inc;
                    parity_next = parity_reg ^ byte_par;
                    if (tpos_reg == 2'd2) begin
                        tpos_next = 2'd0;
                        if (trip_reg < LED_MAX) begin
                            trip_next = trip_reg + 4'd1;
                        end
                    end else begin
                        tpos_next = tpos_reg + 2'd1;
                    end
                    if (cnt_inc >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                if (s_fire) begin
                    if (s_rx_byte != {7'd0, parity_reg}) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_PARITY;
                        phase_next    = PH_HEAD1;
                    end else begin
                        phase_next = PH_FOOT1;
                    end
                end
            end
            PH_FOOT1: begin
                if (s_fire) begin
                    if (s_rx_byte != lfd_pkg::FOOT1_BYTE) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_BAD_FOOT1;
                        phase_next    = PH_HEAD1;
                    end else begin
                        phase_next = PH_FOOT2;
                    end
                end
            end
            PH_FOOT2: begin
                if (s_fire) begin
                    if (s_rx_byte != lfd_pkg::FOOT2_BYTE) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_BAD_FOOT2;
                        phase_next    = PH_HEAD1;
                    end else if (trip_reg == 4'd0) begin
                        m_valid_next  = 1'b1;
                        m_status_next = lfd_pkg::ST_FRAME_OK;
                        phase_next    = PH_HEAD1;
                    end else begin
                        idx_next     = 4'd0;
                        sub_next     = RD_PRIME;
                        rd_addr_next = '0;
                        phase_next   = PH_READ;
                    end
                end
            end
            PH_READ: begin
                if (m_valid_reg) begin
                    // Wait for the output transfer, then move to the next LED.
                    if (m_ready) begin
                        if (m_last_reg) begin
                            phase_next = PH_HEAD1;
                        end else begin
                            idx_next = idx_reg + 4'd1;
                            sub_next = RD_PRIME;
                        end
                    end
                end else begin
                    unique case (sub_reg)
                        RD_PRIME: begin
                            rd_addr_next = rd_addr_reg + AW'(1);
                            sub_next     = RD_RED;
                        end
                        RD_RED: begin
                            red_next     = rd_data;
                            rd_addr_next = rd_addr_reg + AW'(1);
                            sub_next     = RD_GREEN;
                        end
                        RD_GREEN: begin
                            green_next   = rd_data;
                            rd_addr_next = rd_addr_reg + AW'(1);
                            sub_next     = RD_BLUE;
                        end
                        RD_BLUE: begin
                            m_valid_next = 1'b1;
                            sub_next     = RD_PRIME;
                        end
                        default: begin
                            sub_next = RD_PRIME;
                        end
                    endcase
                end
            end
            default: begin
                phase_next = PH_HEAD1;
            end
        endcase

        // Fill the output fields for whichever result was started this cycle.
        if (m_valid_next && !m_valid_reg || m_valid_next && m_ready) begin
            if (phase_reg == PH_READ) begin
                m_status_next = lfd_pkg::ST_LED_WRITE;
                m_index_next  = idx_reg;
                m_red_next    = red_reg;
                m_green_next  = green_reg;
                m_blue_next   = rd_data;
                m_last_next   = ((idx_reg + 4'd1) == trip_reg);
            end else begin
                m_index_next = 4'd0;
                m_red_next   = 8'd0;
                m_green_next = 8'd0;
                m_blue_next  = 8'd0;
                m_last_next  = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD1;
            len_reg     <= 8'd0;
            cnt_reg     <= 8'd0;
            parity_reg  <= 1'b0;
            tpos_reg    <= 2'd0;
            trip_reg    <= 4'd0;
            idx_reg     <= 4'd0;
            sub_reg     <= RD_PRIME;
            rd_addr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            parity_reg  <= parity_next;
            tpos_reg    <= tpos_next;
            trip_reg    <= trip_next;
            idx_reg     <= idx_next;
            sub_reg     <= sub_next;
            rd_addr_reg <= rd_addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        red_reg      <= red_next;
        green_reg    <= green_next;
        m_status_reg <= m_status_next;
        m_index_reg  <= m_index_next;
        m_red_reg    <= m_red_next;
        m_green_reg  <= m_green_next;
        m_blue_reg   <= m_blue_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_led_index = m_index_reg;
    assign m_red       = m_red_reg;
    assign m_green     = m_green_reg;
    assign m_blue      = m_blue_reg;
    assign m_last      = m_last_reg;

`ifndef SYNTHESIS
    // No input is taken while the stored colors are being read out.
    a_no_input_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ |-> !s_ready)
        else $error("input ready during LED readout");

    // Readout only runs for a frame that holds at least one triplet.
    a_readout_has_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ |-> trip_reg != 4'd0)
        else $error("readout started with no complete triplet");

    // An LED write never names an LED past the triplet count.
    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && phase_reg == PH_READ |-> m_index_reg < trip_reg)
        else $error("LED index beyond the triplet count");

    // Store writes stay inside the color store.
    a_store_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        store_wr.en |-> store_wr.addr < AW'(lfd_pkg::STORE_SIZE))
        else $error("color store write out of range");

    // A last LED write ends the readout once it is transferred.
    a_last_ends_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ && m_valid_reg && m_ready && m_last_reg
        |=> phase_reg == PH_HEAD1)
        else $error("readout did not end after the last LED write");
`endif

endmodule
